FILE: hw/rtl/tccs_pkg.sv
// Package for the text console with cursor and scroll.
// Holds the default geometry, the field widths, the mode codes and the controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 11;
  localparam int POS_W  = 11;

  localparam logic [MODE_W-1:0] MODE_PUT       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEWLINE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BACKSPACE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ      = 2'd3;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_COPY  = 6'b000100,
    ST_FILL  = 6'b001000,
    ST_EXEC  = 6'b010000,
    ST_READ  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/text_console_cursor_scroll.sv
// Top level of the text console: character store, write position and scroll sequencer.
// Depends on tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A beat is accepted when start is high and busy is low, and each beat yields exactly one
// result, shown on the out_ ports for one cycle while out_valid is high; the receiver
// cannot stall it. Put, newline and backspace pass through the EXEC state to the registered
// result; a cell read also passes through the READ state because of the store's registered
// read port. A beat that scrolls first passes through the COPY and FILL states: the
// single-port-write store moves one cell per cycle up one row and then clears the last row
// one cell per cycle. After reset the block holds busy while it clears the store.
module text_console_cursor_scroll #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tccs_pkg::MODE_W-1:0] in_mode,
  input  wire logic [tccs_pkg::CHAR_W-1:0] in_char_code,
  input  wire logic [tccs_pkg::ADDR_W-1:0] in_cell_address,
  output logic                             out_valid,
  output logic [tccs_pkg::POS_W-1:0]       out_cursor_pos,
  output logic [tccs_pkg::CHAR_W-1:0]      out_cell_char,
  output logic                             out_scrolled
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int XW    = (PW > tccs_pkg::ADDR_W) ? PW : tccs_pkg::ADDR_W;

  localparam logic [AW-1:0] IDX_LAST_ROW = AW'(LAST);
  localparam logic [AW-1:0] IDX_END      = AW'(CELLS - 1);
  localparam logic [AW-1:0] IDX_COLS     = AW'(COLUMNS);
  localparam logic [PW-1:0] POS_CELLS    = PW'(CELLS);
  localparam logic [PW-1:0] POS_LAST     = PW'(LAST);
  localparam logic [PW-1:0] POS_COLS     = PW'(COLUMNS);
  localparam logic [CW-1:0] COL_MAX      = CW'(COLUMNS - 1);
  localparam logic [XW-1:0] ADDR_CELLS   = XW'(CELLS);

  logic [tccs_pkg::CHAR_W-1:0] mem [CELLS];
  logic [tccs_pkg::CHAR_W-1:0] rdata_r;

  tccs_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          scroll_r, scroll_nxt;
  logic          ov_r, ov_nxt;
  logic [tccs_pkg::POS_W-1:0]  opos_r, opos_nxt;
  logic [tccs_pkg::CHAR_W-1:0] ochar_r, ochar_nxt;
  logic                        oscr_r, oscr_nxt;

  logic [tccs_pkg::MODE_W-1:0] mode_r;
  logic [tccs_pkg::CHAR_W-1:0] char_r;
  logic [tccs_pkg::ADDR_W-1:0] addr_r;

  logic                        we_c;
  logic [AW-1:0]               waddr_c;
  logic [AW-1:0]               raddr_c;
  logic [tccs_pkg::CHAR_W-1:0] wdata_c;
  logic [XW-1:0]               addr_x;
  logic                        accept_c;

  assign addr_x   = XW'(addr_r);
  assign accept_c = start && (state_r == tccs_pkg::ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    col_nxt    = col_r;
    scroll_nxt = scroll_r;
    ov_nxt     = 1'b0;
    opos_nxt   = opos_r;
    ochar_nxt  = ochar_r;
    oscr_nxt   = oscr_r;
    we_c       = 1'b0;
    waddr_c    = cnt_r;
    wdata_c    = '0;
    raddr_c    = addr_x[AW-1:0];
    case (state_r)
      tccs_pkg::ST_CLEAR: begin
        we_c = 1'b1;
        if (cnt_r == IDX_END) begin
          cnt_nxt   = '0;
          state_nxt = tccs_pkg::ST_IDLE;
        end else begin
          cnt_nxt = AW'(cnt_r + 1'b1);
        end
      end
      tccs_pkg::ST_IDLE: begin
        if (start) begin
          if (((in_mode == tccs_pkg::MODE_PUT) && (pos_r >= POS_CELLS)) ||
              ((in_mode == tccs_pkg::MODE_NEWLINE) && (pos_r > POS_LAST))) begin
            scroll_nxt = 1'b1;
            pos_nxt    = PW'(pos_r - POS_COLS);
            cnt_nxt    = '0;
            state_nxt  = tccs_pkg::ST_COPY;
          end else begin
            scroll_nxt = 1'b0;
            state_nxt  = tccs_pkg::ST_EXEC;
          end
        end
      end
      tccs_pkg::ST_COPY: begin
        raddr_c = AW'(cnt_r + IDX_COLS);
        if (cnt_r != '0) begin
          we_c    = 1'b1;
          waddr_c = AW'(cnt_r - 1'b1);
          wdata_c = rdata_r;
        end
        if (cnt_r == IDX_LAST_ROW) begin
          state_nxt = tccs_pkg::ST_FILL;
        end else begin
          cnt_nxt = AW'(cnt_r + 1'b1);
        end
      end
      tccs_pkg::ST_FILL: begin
        we_c = 1'b1;
        if (cnt_r == IDX_END) begin
          cnt_nxt   = '0;
          state_nxt = tccs_pkg::ST_EXEC;
        end else begin
          cnt_nxt = AW'(cnt_r + 1'b1);
        end
      end
      tccs_pkg::ST_EXEC: begin
        state_nxt = tccs_pkg::ST_IDLE;
        case (mode_r)
          tccs_pkg::MODE_PUT: begin
            we_c    = 1'b1;
            waddr_c = pos_r[AW-1:0];
            wdata_c = char_r;
            pos_nxt = PW'(pos_r + 1'b1);
            col_nxt = (col_r == COL_MAX) ? '0 : CW'(col_r + 1'b1);
          end
          tccs_pkg::MODE_NEWLINE: begin
            pos_nxt = PW'(pos_r - PW'(col_r) + POS_COLS);
            col_nxt = '0;
          end
          tccs_pkg::MODE_BACKSPACE: begin
            if (pos_r != '0) begin
              we_c    = 1'b1;
              waddr_c = AW'(pos_r - 1'b1);
              pos_nxt = PW'(pos_r - 1'b1);
              col_nxt = (col_r == '0) ? COL_MAX : CW'(col_r - 1'b1);
            end
          end
          tccs_pkg::MODE_READ: begin
            state_nxt = tccs_pkg::ST_READ;
          end
          default: begin
            state_nxt = tccs_pkg::ST_READ;
          end
        endcase
        if (state_nxt == tccs_pkg::ST_IDLE) begin
          ov_nxt    = 1'b1;
          opos_nxt  = tccs_pkg::POS_W'(pos_nxt);
          ochar_nxt = '0;
          oscr_nxt  = scroll_r;
        end
      end
      tccs_pkg::ST_READ: begin
        state_nxt = tccs_pkg::ST_IDLE;
        ov_nxt    = 1'b1;
        opos_nxt  = tccs_pkg::POS_W'(pos_r);
        ochar_nxt = (addr_x < ADDR_CELLS) ? rdata_r : '0;
        oscr_nxt  = 1'b0;
      end
      default: begin
        state_nxt = tccs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    rdata_r <= mem[raddr_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tccs_pkg::ST_CLEAR;
      cnt_r    <= '0;
      pos_r    <= '0;
      col_r    <= '0;
      scroll_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      col_r    <= col_nxt;
      scroll_r <= scroll_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opos_r  <= opos_nxt;
    ochar_r <= ochar_nxt;
    oscr_r  <= oscr_nxt;
    if (accept_c) begin
      mode_r <= in_mode;
      char_r <= in_char_code;
      addr_r <= in_cell_address;
    end
  end

  assign busy           = (state_r != tccs_pkg::ST_IDLE);
  assign out_valid      = ov_r;
  assign out_cursor_pos = opos_r;
  assign out_cell_char  = ochar_r;
  assign out_scrolled   = oscr_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tccs_checker.sv
// Port-level checker for the text console, bound to the top level.
// Depends on tccs_pkg and on text_console_cursor_scroll.
`timescale 1ns / 1ps
`default_nettype none

module tccs_checker #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic [tccs_pkg::POS_W-1:0]  out_cursor_pos,
  input wire logic                        out_scrolled
);

  localparam logic [tccs_pkg::POS_W-1:0] POS_CELLS  = tccs_pkg::POS_W'(COLUMNS * ROWS);
  localparam logic [tccs_pkg::POS_W-1:0] POS_LAST   =
    tccs_pkg::POS_W'(COLUMNS * ROWS - COLUMNS);
  localparam logic [tccs_pkg::POS_W-1:0] POS_AFTER  =
    tccs_pkg::POS_W'(COLUMNS * ROWS - COLUMNS + 1);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result appeared without preceding work");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_pos <= POS_CELLS)
    else $error("cursor position beyond the screen");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> (out_cursor_pos == POS_AFTER) ||
                                  (out_cursor_pos == POS_LAST) ||
                                  (out_cursor_pos == POS_CELLS))
    else $error("scroll left the cursor at an unexpected position");

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_tccs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_cursor_pos(out_cursor_pos),
  .out_scrolled(out_scrolled)
);

`default_nettype wire

FILE: test/tb_text_console_cursor_scroll.sv
// Testbench for text_console_cursor_scroll: drives put, newline, backspace and read beats,
// predicts cursor, cell and scroll results from its own screen copy and checks each one.
// Depends on tccs_pkg and the text_console_cursor_scroll RTL.
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;
  import tccs_pkg::*;

  localparam int COLS           = COLUMNS_DEF;
  localparam int CELLS          = COLUMNS_DEF * ROWS_DEF;
  localparam int LAST_ROW_START = CELLS - COLUMNS_DEF;
  localparam int ITEM_TARGET    = 1650;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
    int unsigned       idle_pct;
  } console_cmd_t;

  typedef struct {
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic              scrolled;
  } console_echo_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [MODE_W-1:0] in_mode = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [ADDR_W-1:0] in_cell_address = '0;
  logic              busy;
  logic              out_valid;
  logic [POS_W-1:0]  out_cursor_pos;
  logic [CHAR_W-1:0] out_cell_char;
  logic              out_scrolled;

  console_cmd_t  pending_cmds[$];
  console_echo_t expected_echoes[$];
  console_cmd_t  next_cmd;
  console_cmd_t  taken_cmd;
  console_echo_t seen_echo;
  console_echo_t want_echo;

  logic [CHAR_W-1:0] screen_copy [CELLS];
  int                model_cursor = 0;
  int                gen_cursor = 0;
  int                beats_offered = 0;
  int                beats_taken = 0;
  int                total_beats = 0;
  int                quiet_cycles = 0;
  int                failures = 0;
  int unsigned       phase_idle [3] = '{9, 57, 0};

  text_console_cursor_scroll dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_char_code    (in_char_code),
    .in_cell_address (in_cell_address),
    .out_valid       (out_valid),
    .out_cursor_pos  (out_cursor_pos),
    .out_cell_char   (out_cell_char),
    .out_scrolled    (out_scrolled)
  );

  always #10 clk = ~clk;

  function automatic void scroll_screen();
    for (int i = 0; i < LAST_ROW_START; i++) screen_copy[i] = screen_copy[i + COLS];
    for (int i = LAST_ROW_START; i < CELLS; i++) screen_copy[i] = '0;
    model_cursor = (model_cursor >= COLS) ? model_cursor - COLS : 0;
  endfunction

  function automatic console_echo_t predict_console(console_cmd_t cmd);
    console_echo_t echo;
    echo.cell_char = '0;
    echo.scrolled  = 1'b0;
    case (cmd.mode)
      MODE_PUT: begin
        if (model_cursor >= CELLS) begin
          scroll_screen();
          echo.scrolled = 1'b1;
        end
        screen_copy[model_cursor] = cmd.char_code;
        model_cursor++;
      end
      MODE_NEWLINE: begin
        if (model_cursor > LAST_ROW_START) begin
          scroll_screen();
          echo.scrolled = 1'b1;
        end
        model_cursor += COLS - (model_cursor % COLS);
        if (model_cursor > CELLS) model_cursor = CELLS;
      end
      MODE_BACKSPACE: begin
        if (model_cursor != 0) begin
          model_cursor--;
          screen_copy[model_cursor] = '0;
        end
      end
      default: begin
        if (cmd.cell_address < CELLS) echo.cell_char = screen_copy[cmd.cell_address];
      end
    endcase
    echo.cursor_pos = model_cursor[POS_W-1:0];
    return echo;
  endfunction

  // The rough cursor kept here only steers the stimulus: toward or away from scrolling, and addresses near the cursor.
  function automatic void add_cmd(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] code,
                                  logic [ADDR_W-1:0] addr, int unsigned idle);
    console_cmd_t cmd;
    cmd.mode         = mode;
    cmd.char_code    = code;
    cmd.cell_address = addr;
    cmd.idle_pct     = idle;
    pending_cmds.insert(pending_cmds.size(), cmd);
    case (mode)
      MODE_PUT:       gen_cursor = (gen_cursor >= CELLS) ? LAST_ROW_START + 1 : gen_cursor + 1;
      MODE_NEWLINE:   gen_cursor = ((gen_cursor / COLS) + 1) * COLS > CELLS ?
                                   CELLS : ((gen_cursor / COLS) + 1) * COLS;
      MODE_BACKSPACE: gen_cursor = (gen_cursor > 0) ? gen_cursor - 1 : 0;
      default: ;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int near;
    near = gen_cursor - int'($urandom_range(200));
    if ($urandom_range(1) == 0 || near < 0) return ADDR_W'($urandom_range(2047));
    return ADDR_W'(near);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(3) == 0) return CHAR_W'($urandom_range(255));
    return CHAR_W'($urandom_range(126, 32));
  endfunction

  always @(negedge clk) begin
    if (rst_n && (!start || beats_taken == beats_offered)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        in_mode         <= next_cmd.mode;
        in_char_code    <= next_cmd.char_code;
        in_cell_address <= next_cmd.cell_address;
        start           <= 1'b1;
        beats_offered++;
      end else begin
        in_mode         <= MODE_W'($urandom_range(3));
        in_char_code    <= CHAR_W'($urandom_range(255));
        in_cell_address <= ADDR_W'($urandom_range(2047));
        start           <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      beats_taken  <= 0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid) begin
        seen_echo.cursor_pos = out_cursor_pos;
        seen_echo.cell_char  = out_cell_char;
        seen_echo.scrolled   = out_scrolled;
        if (expected_echoes.size() == 0) begin
          if (failures < MAX_REPORTS)
            $display("%0t: result with nothing expected: pos %0d char %h scrolled %b",
                     $realtime, seen_echo.cursor_pos, seen_echo.cell_char, seen_echo.scrolled);
          failures++;
        end else begin
          want_echo = expected_echoes.pop_front();
          if (seen_echo.cursor_pos !== want_echo.cursor_pos ||
              seen_echo.cell_char !== want_echo.cell_char ||
              seen_echo.scrolled !== want_echo.scrolled) begin
            if (failures < MAX_REPORTS)
              $display("%0t: mismatch: pos exp %0d got %0d, char exp %h got %h, %s %b got %b",
                       $realtime, want_echo.cursor_pos, seen_echo.cursor_pos,
                       want_echo.cell_char, seen_echo.cell_char, "scrolled exp",
                       want_echo.scrolled, seen_echo.scrolled);
            failures++;
          end
        end
      end
      if (start && !busy) begin
        taken_cmd.mode         = in_mode;
        taken_cmd.char_code    = in_char_code;
        taken_cmd.cell_address = in_cell_address;
        taken_cmd.idle_pct     = 0;
        expected_echoes.insert(expected_echoes.size(), predict_console(taken_cmd));
        beats_taken <= beats_taken + 1;
      end
      quiet_cycles <= (out_valid || (start && !busy)) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned idle;
    int          pick;
    int          burst;
    for (int i = 0; i < CELLS; i++) screen_copy[i] = '0;

    idle = phase_idle[0];
    add_cmd(MODE_BACKSPACE, pick_char(), pick_address(), idle);
    add_cmd(MODE_READ, pick_char(), 11'd2047, idle);
    add_cmd(MODE_READ, pick_char(), 11'd1999, idle);
    add_cmd(MODE_PUT, 8'h00, pick_address(), idle);
    add_cmd(MODE_PUT, 8'hFF, pick_address(), idle);
    add_cmd(MODE_READ, pick_char(), 11'd1, idle);
    add_cmd(MODE_BACKSPACE, pick_char(), pick_address(), idle);
    add_cmd(MODE_READ, pick_char(), 11'd1, idle);
    repeat (24) add_cmd(MODE_NEWLINE, pick_char(), pick_address(), idle);
    add_cmd(MODE_NEWLINE, pick_char(), pick_address(), idle);
    add_cmd(MODE_PUT, 8'hA5, pick_address(), idle);
    add_cmd(MODE_READ, pick_char(), 11'd1920, idle);
    add_cmd(MODE_NEWLINE, pick_char(), pick_address(), idle);
    add_cmd(MODE_READ, pick_char(), 11'd1840, idle);
    add_cmd(MODE_READ, pick_char(), 11'd1920, idle);

    while (pending_cmds.size() < ITEM_TARGET) begin
      idle = phase_idle[(pending_cmds.size() * 3 / ITEM_TARGET) > 2 ?
                        2 : pending_cmds.size() * 3 / ITEM_TARGET];
      pick = $urandom_range(10);
      if (pick <= 5) begin
        burst = ($urandom_range(3) == 0) ? $urandom_range(100, 1) : $urandom_range(12, 1);
        repeat (burst) add_cmd(MODE_PUT, pick_char(), pick_address(), idle);
      end else if (pick <= 7) begin
        if (gen_cursor > LAST_ROW_START && $urandom_range(3) != 0)
          add_cmd(MODE_BACKSPACE, pick_char(), pick_address(), idle);
        else
          add_cmd(MODE_NEWLINE, pick_char(), pick_address(), idle);
      end else if (pick == 8) begin
        repeat ($urandom_range(6, 1)) add_cmd(MODE_BACKSPACE, pick_char(), pick_address(), idle);
      end else if (pick == 9) begin
        repeat ($urandom_range(4, 1)) add_cmd(MODE_READ, pick_char(), pick_address(), idle);
      end else begin
        add_cmd(MODE_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                ADDR_W'($urandom_range(2047)), idle);
      end
    end
    total_beats = pending_cmds.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(beats_taken == total_beats && expected_echoes.size() == 0) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      failures += expected_echoes.size();
      if (failures == 0)
        $display("Verification passed");
      else
        $display("Verification failed");
    end
    $finish;
  end

endmodule
